>>> design/mf3_pkg.sv
package mf3_pkg;

   // build-time defaults
   localparam int DEF_MAX_WIDTH    = 2048;
   localparam int DEF_CHANNEL_BITS = 16;

   // fixed field and register widths
   localparam int NUM_CH          = 3;
   localparam int CSR_DATA_BITS   = 13;
   localparam int WIDTH_REG_BITS  = 12;
   localparam int HEIGHT_REG_BITS = 13;
   localparam int ROW_BITS        = 12;
   localparam int OUT_COL_BITS    = 11;

   // frame limits and reset values
   localparam int MIN_DIM      = 3;
   localparam int MAX_HEIGHT   = 4096;
   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

endpackage

>>> design/mf3_ifs.sv
interface mf3_pix_if #(
   parameter int CHANNEL_BITS = mf3_pkg::DEF_CHANNEL_BITS
);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] pix_red;
   logic [CHANNEL_BITS-1:0] pix_green;
   logic [CHANNEL_BITS-1:0] pix_blue;

   modport source (output valid, pix_red, pix_green, pix_blue, input ready);
   modport sink   (input valid, pix_red, pix_green, pix_blue, output ready);
endinterface

interface mf3_med_if #(
   parameter int CHANNEL_BITS = mf3_pkg::DEF_CHANNEL_BITS
);
   import mf3_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] med_red;
   logic [CHANNEL_BITS-1:0] med_green;
   logic [CHANNEL_BITS-1:0] med_blue;
   logic [OUT_COL_BITS-1:0] out_col;
   logic [ROW_BITS-1:0]     out_row;
   logic                    frame_last;

   modport source (output valid, med_red, med_green, med_blue, out_col, out_row,
                   frame_last, input ready);
   modport sink   (input valid, med_red, med_green, med_blue, out_col, out_row,
                   frame_last, output ready);
endinterface

>>> design/mf3_ram.sv
module mf3_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> design/median_3x3_rgb_filter.sv
// Streaming 3x3 median filter for RGB pixels. Pixels enter in raster order, one beat per
// clock sustained unless rsp_ch.ready stalls output; each interior pixel of the frame
// yields one result beat (per-channel true median of nine) via the stage registers and
// the output register after the beat completing its neighbourhood; first/last rows and
// columns give no beat. The two rows above the incoming pixel share one line-store RAM
// word, read on accept and written back as stage 1 moves on, so its read-modify-write
// sets the one-pixel-per-clock rate. The line store needs no clearing pass after reset.
// image_width and image_height are clamped to 3..MAX_WIDTH and 3..4096 and should only
// be written while the block is idle.
module median_3x3_rgb_filter #(
   parameter int MAX_WIDTH    = mf3_pkg::DEF_MAX_WIDTH,
   parameter int CHANNEL_BITS = mf3_pkg::DEF_CHANNEL_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   mf3_pix_if.sink                            req_ch,
   mf3_med_if.source                          rsp_ch,
   input  logic                               csr_wr_en,
   input  mf3_pkg::csr_index_type             csr_index,
   input  logic [mf3_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import mf3_pkg::*;

   localparam int CB = CHANNEL_BITS;
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = CW + 1;
   localparam int PW = NUM_CH * CB;

   function automatic logic [CB-1:0] max2(input logic [CB-1:0] a, input logic [CB-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [CB-1:0] min2(input logic [CB-1:0] a, input logic [CB-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [CB-1:0] med3(input logic [CB-1:0] a, input logic [CB-1:0] b,
                                          input logic [CB-1:0] c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // returns {high, mid, low}
   function automatic logic [3*CB-1:0] sort3(input logic [CB-1:0] a, input logic [CB-1:0] b,
                                             input logic [CB-1:0] c);
      logic [CB-1:0] x0;
      logic [CB-1:0] x1;
      logic [CB-1:0] y1;
      logic [CB-1:0] y2;
      x0 = min2(a, b);
      x1 = max2(a, b);
      y1 = min2(x1, c);
      y2 = max2(x1, c);
      return {y2, max2(x0, y1), min2(x0, y1)};
   endfunction

   function automatic logic [EW-1:0] clamp_width(input logic [WIDTH_REG_BITS-1:0] v);
      if (int'(v) < MIN_DIM) begin
         return EW'(MIN_DIM);
      end else if (int'(v) > MAX_WIDTH) begin
         return EW'(MAX_WIDTH);
      end
      return EW'(v);
   endfunction

   function automatic logic [HEIGHT_REG_BITS-1:0] clamp_height(
      input logic [HEIGHT_REG_BITS-1:0] v);
      if (int'(v) < MIN_DIM) begin
         return HEIGHT_REG_BITS'(MIN_DIM);
      end else if (int'(v) > MAX_HEIGHT) begin
         return HEIGHT_REG_BITS'(MAX_HEIGHT);
      end
      return v;
   endfunction

   // configuration
   logic [EW-1:0]              width_ff;
   logic [HEIGHT_REG_BITS-1:0] height_ff;

   // position of the next pixel
   logic [CW-1:0]       col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;

   // handshake and stage control
   logic accept;
   logic s1_vld_ff, s1_vld_in;
   logic s2_vld_ff, s2_vld_in;
   logic s3_vld_ff, s3_vld_in;
   logic rsp_vld_ff, rsp_vld_in;
   logic out_load, s3_free, s2_adv, s2_free, s1_adv, s1_free;

   // position decode
   logic [CW:0]         col_inc;
   logic [ROW_BITS:0]   row_inc;
   logic                col_end, row_end, emit, last;
   logic [CW-1:0]       col_m1;
   logic [ROW_BITS-1:0] row_m1;

   // stage 1: line store read in flight
   logic [PW-1:0]           s1_pix_ff;
   logic [CW-1:0]           s1_col_ff;
   logic                    s1_emit_ff, s1_last_ff;
   logic [OUT_COL_BITS-1:0] s1_ocol_ff;
   logic [ROW_BITS-1:0]     s1_orow_ff;

   // stage 2: new column sorted
   logic [3*CB-1:0]         s2_col_ff [NUM_CH];
   logic [3*CB-1:0]         s2_col_in [NUM_CH];
   logic                    s2_emit_ff, s2_last_ff;
   logic [OUT_COL_BITS-1:0] s2_ocol_ff;
   logic [ROW_BITS-1:0]     s2_orow_ff;

   // window of the two previous columns, each kept sorted
   logic [3*CB-1:0] win_ff [2][NUM_CH];

   // stage 3: max of lows, median of middles, min of highs
   logic [CB-1:0]           s3_lo_ff [NUM_CH];
   logic [CB-1:0]           s3_mid_ff [NUM_CH];
   logic [CB-1:0]           s3_hi_ff [NUM_CH];
   logic [CB-1:0]           s3_lo_in [NUM_CH];
   logic [CB-1:0]           s3_mid_in [NUM_CH];
   logic [CB-1:0]           s3_hi_in [NUM_CH];
   logic                    s3_last_ff;
   logic [OUT_COL_BITS-1:0] s3_ocol_ff;
   logic [ROW_BITS-1:0]     s3_orow_ff;

   // output register
   logic [CB-1:0]           rsp_med_ff [NUM_CH];
   logic [CB-1:0]           rsp_med_in [NUM_CH];
   logic                    rsp_last_ff;
   logic [OUT_COL_BITS-1:0] rsp_ocol_ff;
   logic [ROW_BITS-1:0]     rsp_orow_ff;

   // line store: {row above middle, middle row}
   logic            ram_rd_en, ram_wr_en;
   logic [CW-1:0]   ram_rd_addr, ram_wr_addr;
   logic [2*PW-1:0] ram_rd_data, ram_wr_data;

   mf3_ram #(
      .WIDTH (2 * PW),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // flow control, one stage at a time from the output back
   assign out_load = s3_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign s3_free  = !s3_vld_ff || out_load;
   assign s2_adv   = s2_vld_ff && (!s2_emit_ff || s3_free);
   assign s2_free  = !s2_vld_ff || s2_adv;
   assign s1_adv   = s1_vld_ff && s2_free;
   assign s1_free  = !s1_vld_ff || s1_adv;

   assign req_ch.ready = s1_free;
   assign accept       = req_ch.valid && s1_free;

   assign s1_vld_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_ff);
   assign s2_vld_in  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_vld_ff);
   assign s3_vld_in  = (s2_adv && s2_emit_ff) ? 1'b1 : (out_load ? 1'b0 : s3_vld_ff);
   assign rsp_vld_in = out_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_vld_ff);

   // position decode
   assign col_inc = {1'b0, col_ff} + 1'b1;
   assign row_inc = {1'b0, row_ff} + 1'b1;
   assign col_end = col_inc >= width_ff;
   assign row_end = row_inc >= height_ff;
   assign emit    = (col_ff >= CW'(2)) && (row_ff >= ROW_BITS'(2))
                    && ({1'b0, col_ff} < width_ff) && ({1'b0, row_ff} < height_ff);
   assign last    = col_end && row_end;
   assign col_m1  = col_ff - 1'b1;
   assign row_m1  = row_ff - 1'b1;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_inc[ROW_BITS-1:0];
         end else begin
            col_in = col_inc[CW-1:0];
         end
      end
   end

   // line store: read on accept, write back as stage 1 moves on
   assign ram_rd_en   = accept;
   assign ram_rd_addr = col_ff;
   assign ram_wr_en   = s1_adv;
   assign ram_wr_addr = s1_col_ff;
   assign ram_wr_data = {ram_rd_data[PW-1:0], s1_pix_ff};

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         s2_col_in[ch] = sort3(ram_rd_data[PW + ch*CB +: CB], ram_rd_data[ch*CB +: CB],
                               s1_pix_ff[ch*CB +: CB]);
      end
   end

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         s3_lo_in[ch]  = max2(max2(win_ff[0][ch][0 +: CB], win_ff[1][ch][0 +: CB]),
                              s2_col_ff[ch][0 +: CB]);
         s3_mid_in[ch] = med3(win_ff[0][ch][CB +: CB], win_ff[1][ch][CB +: CB],
                              s2_col_ff[ch][CB +: CB]);
         s3_hi_in[ch]  = min2(min2(win_ff[0][ch][2*CB +: CB], win_ff[1][ch][2*CB +: CB]),
                              s2_col_ff[ch][2*CB +: CB]);
         rsp_med_in[ch] = med3(s3_lo_ff[ch], s3_mid_ff[ch], s3_hi_ff[ch]);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= clamp_width(WIDTH_REG_BITS'(RESET_WIDTH));
         height_ff  <= clamp_height(HEIGHT_REG_BITS'(RESET_HEIGHT));
         col_ff     <= '0;
         row_ff     <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH: begin
                  width_ff <= clamp_width(csr_wdata[WIDTH_REG_BITS-1:0]);
               end
               CSR_IMAGE_HEIGHT: begin
                  height_ff <= clamp_height(csr_wdata[HEIGHT_REG_BITS-1:0]);
               end
               default: begin
               end
            endcase
         end
         col_ff     <= col_in;
         row_ff     <= row_in;
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         s3_vld_ff  <= s3_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= {req_ch.pix_blue, req_ch.pix_green, req_ch.pix_red};
         s1_col_ff  <= col_ff;
         s1_emit_ff <= emit;
         s1_last_ff <= last;
         s1_ocol_ff <= OUT_COL_BITS'(col_m1);
         s1_orow_ff <= row_m1;
      end
      if (s1_adv) begin
         s2_col_ff  <= s2_col_in;
         s2_emit_ff <= s1_emit_ff;
         s2_last_ff <= s1_last_ff;
         s2_ocol_ff <= s1_ocol_ff;
         s2_orow_ff <= s1_orow_ff;
      end
      if (s2_adv) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= s2_col_ff;
         if (s2_emit_ff) begin
            s3_lo_ff   <= s3_lo_in;
            s3_mid_ff  <= s3_mid_in;
            s3_hi_ff   <= s3_hi_in;
            s3_last_ff <= s2_last_ff;
            s3_ocol_ff <= s2_ocol_ff;
            s3_orow_ff <= s2_orow_ff;
         end
      end
      if (out_load) begin
         rsp_med_ff  <= rsp_med_in;
         rsp_last_ff <= s3_last_ff;
         rsp_ocol_ff <= s3_ocol_ff;
         rsp_orow_ff <= s3_orow_ff;
      end
   end

   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.med_red    = rsp_med_ff[0];
   assign rsp_ch.med_green  = rsp_med_ff[1];
   assign rsp_ch.med_blue   = rsp_med_ff[2];
   assign rsp_ch.out_col    = rsp_ocol_ff;
   assign rsp_ch.out_row    = rsp_orow_ff;
   assign rsp_ch.frame_last = rsp_last_ff;

   // consecutive pixels never touch the same line store entry in one cycle
   assert property (@(posedge clock) disable iff (reset)
      (ram_rd_en && ram_wr_en) |-> (ram_rd_addr != ram_wr_addr))
      else $error("line store read and write collide");

   // a new read must not overwrite data that stage 1 still holds
   assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> (!s1_vld_ff || s1_adv))
      else $error("line store read data lost");

   assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> s2_vld_ff)
      else $error("beat dropped between stage 1 and stage 2");

   assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_vld_ff)
      else $error("result beat dropped at output register");

endmodule
